FILE: rtl/lfo_swept_allpass_phaser_defines.svh
// Assertion macros shared by the phaser RTL.
`ifndef LFO_SWEPT_ALLPASS_PHASER_DEFINES_SVH
`define LFO_SWEPT_ALLPASS_PHASER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("phaser assertion failed");

// Next-cycle implication, disabled during reset.
`define LSAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("phaser assertion failed");

`endif

FILE: rtl/lsap_pkg.sv
// Package with shared types, constants and constant tables of the phaser.
package lsap_pkg;

	// Fixed table sizes and sample rate.
	localparam int SINE_DEPTH  = 256;
	localparam int COEFF_DEPTH = 256;
	localparam int SAMPLE_RATE = 48000;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_DEPTH      = 3'd1;
	localparam logic [2:0] REG_STAGES     = 3'd2;
	localparam logic [2:0] REG_FEEDBACK   = 3'd3;
	localparam logic [2:0] REG_MIX        = 3'd4;
	localparam logic [2:0] REG_SHAPE      = 3'd5;

	// LFO waveform codes; the unused code acts as sine.
	localparam logic [1:0] SHAPE_SINE   = 2'd0;
	localparam logic [1:0] SHAPE_TRI    = 2'd1;
	localparam logic [1:0] SHAPE_SQUARE = 2'd2;

	// Polynomial constants of the quarter-wave sine in Q30.
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] PA      = 64'd1686629713;
	localparam logic [63:0] PB      = 64'd693598668;
	localparam logic [63:0] PC      = 64'd85569306;
	localparam logic [63:0] PD      = 64'd5026995;

	typedef logic signed [15:0] sine_tbl_t  [SINE_DEPTH];
	typedef logic signed [16:0] coeff_tbl_t [COEFF_DEPTH];

	// Operands of the shared multiplier.
	typedef struct packed {
		logic signed [24:0] a;
		logic signed [17:0] b;
	} mul_req_t;

	// Sine of a turn fraction in Q32, result in Q30.
	function automatic longint sin_q30(input logic [31:0] turn);
		logic [1:0]  quad;
		logic [63:0] frac;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		quad = turn[31:30];
		frac = {34'd0, turn[29:0]};
		x    = quad[0] ? (Q30_ONE - frac) : frac;
		x2   = (x * x) >> 30;
		t    = PC - ((x2 * PD) >> 30);
		t    = PB - ((x2 * t) >> 30);
		t    = PA - ((x2 * t) >> 30);
		v    = (x * t) >> 30;
		if (v > Q30_ONE) v = Q30_ONE;
		return quad[1] ? -longint'(v) : longint'(v);
	endfunction

	// Unsigned restoring division, used only while building the tables.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sine table in Q1.15, evaluated at elaboration.
	function automatic sine_tbl_t gen_sine();
		sine_tbl_t   tbl;
		longint      s;
		logic [63:0] m;
		for (int k = 0; k < SINE_DEPTH; k++) begin
			s = sin_q30(32'(64'(k) << 24));
			m = (s < 0) ? 64'(-s) : 64'(s);
			m = (m + 64'd16384) >> 15;
			if (m > 64'd32767) m = 64'd32767;
			tbl[k] = (s < 0) ? -16'(m) : 16'(m);
		end
		return tbl;
	endfunction

	// All-pass coefficient table over the 200 Hz to 8000 Hz sweep.
	function automatic coeff_tbl_t gen_coeff();
		coeff_tbl_t  tbl;
		logic [63:0] num;
		logic [63:0] dv;
		logic [31:0] turn;
		longint      sn;
		longint      cs;
		longint      den;
		longint      prod_s;
		logic [63:0] mag;
		logic [63:0] q;
		dv = 64'(SAMPLE_RATE) * 64'(COEFF_DEPTH - 1);
		for (int i = 0; i < COEFF_DEPTH; i++) begin
			num  = (64'(200 * (COEFF_DEPTH - 1)) + 64'd7800 * 64'(i)) << 31;
			turn = 32'(udiv64(num, dv));
			sn   = sin_q30(turn);
			cs   = sin_q30(turn + 32'h4000_0000);
			den  = cs + sn;
			if (den <= 0) begin
				tbl[i] = '0;
			end else begin
				// Quotient truncated toward zero.
				prod_s = (cs - sn) * 64'sd32768;
				mag    = (prod_s < 0) ? 64'(-prod_s) : 64'(prod_s);
				q      = udiv64(mag, 64'(den));
				tbl[i] = (prod_s < 0) ? 17'(-longint'(q)) : 17'(longint'(q));
			end
		end
		return tbl;
	endfunction

	localparam sine_tbl_t  SINE_TBL  = gen_sine();
	localparam coeff_tbl_t COEFF_TBL = gen_coeff();

	// Saturation to 24 and 16 signed bits.
	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v < -48'sd8388608) return -24'sd8388608;
		if (v > 48'sd8388607) return 24'sd8388607;
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		if (v < -48'sd32768) return -16'sd32768;
		if (v > 48'sd32767) return 16'sd32767;
		return v[15:0];
	endfunction

endpackage

FILE: rtl/lsap_mul.sv
// Shared signed multiplier with a registered product.
module lsap_mul (
	input  logic                  clk,
	input  lsap_pkg::mul_req_t    req,
	output logic signed [42:0]    prod
);
	import lsap_pkg::*;

	// Product register; the sequencer reads it in the cycle after issue.
	always_ff @(posedge clk) begin
		prod <= 43'(req.a) * 43'(req.b);
	end

endmodule

FILE: rtl/lfo_swept_allpass_phaser.sv
// Top level of the LFO-swept all-pass phaser with its sequencer and state.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | sample, frame_end
//  out     | output    | out_valid / out_ready| out_sample, frame_peak, last
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An accepted sample passes through the steps LFO, IDX, COEF, DIV and DIV2,
// then A and B for each stage, then W, M1 and M2 into the result register;
// the sequencer then returns to idle, the only step that accepts a sample;
// the shared multiplier is used twice per all-pass stage.
// Asynchronous reset restores register defaults and clears the persistent state.
// A result waiting in the output register holds the sequencer only at its final
// step, so the next sample is accepted while the result is pending.
`include "lfo_swept_allpass_phaser_defines.svh"

module lfo_swept_allpass_phaser #(
	parameter int MAX_STAGES = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample,
	input  logic               frame_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] out_sample,
	output logic [15:0]        frame_peak,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data
);
	import lsap_pkg::*;

	localparam int CW = $clog2(MAX_STAGES + 1);
	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam logic [4:0] MAX5 = 5'(MAX_STAGES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_LFO, ST_IDX, ST_COEF, ST_DIV, ST_DIV2,
		ST_A, ST_B, ST_W, ST_M1, ST_M2
	} state_t;

	state_t state_q;

	// Configuration registers, held in their clamped form.
	logic [20:0] phase_step_q;
	logic [16:0] dep_q;
	logic [CW-1:0] cnt_q;
	logic [15:0] fb_q;
	logic [16:0] mix_q;
	logic [1:0]  shape_q;

	// Persistent state.
	logic [31:0]        phase_q;
	logic signed [23:0] wet_q;
	logic signed [23:0] hist_q [MAX_STAGES];
	logic [15:0]        peak_q;

	// Per-sample working registers.
	logic signed [15:0] dry_q;
	logic               fend_q;
	logic [7:0]         idx_q;
	logic [15:0]        abs_a_q;
	logic               neg_q;
	logic [10:0]        qa_q;
	logic [4:0]         ra_q;
	logic [15:0]        qp_q;
	logic [4:0]         rem_q;
	logic [CW-1:0]      stg_q;
	logic signed [23:0] x_q;
	logic signed [23:0] y_q;
	logic signed [42:0] acc_q;
	logic               out_valid_q;
	logic signed [15:0] out_sample_q;
	logic [15:0]        frame_peak_q;
	logic               last_q;

	logic signed [42:0] prod_q;
	mul_req_t           mreq;

	lsap_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod_q)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign frame_peak = frame_peak_q;
	assign last       = last_q;

	// LFO value from the current phase.
	logic [15:0]        p16;
	logic signed [17:0] two_p;
	logic signed [17:0] lfo;
	always_comb begin
		p16   = phase_q[31:16];
		two_p = {1'b0, p16, 1'b0};
		unique case (shape_q)
			SHAPE_TRI:    lfo = p16[15] ? (18'sd98304 - two_p) : (two_p - 18'sd32768);
			SHAPE_SQUARE: lfo = p16[15] ? -18'sd32768 : 18'sd32768;
			default:      lfo = 18'(SINE_TBL[phase_q[31:24]]);
		endcase
	end

	// Sweep position and coefficient table index.
	logic signed [42:0] sh_w;
	logic signed [27:0] u_raw;
	logic [16:0]        u;
	logic [25:0]        idx_sum;
	always_comb begin
		sh_w  = prod_q >>> 16;
		u_raw = 28'(sh_w) + 28'sd32768;
		if (u_raw < 28'sd0) u = '0;
		else if (u_raw > 28'sd65536) u = 17'd65536;
		else u = u_raw[16:0];
		idx_sum = {1'b0, u, 8'd0} - {9'd0, u} + 26'd32768;
	end

	// Chain input with feedback, and the looked-up base coefficient.
	logic signed [16:0] a_tbl;
	logic signed [23:0] x_in;
	always_comb begin
		a_tbl = COEFF_TBL[idx_q];
		x_in  = sat24(48'(dry_q) + ((48'(prod_q) + 48'sd32768) >>> 16));
	end

	// Stage coefficient: |a| + floor(|a| * s / 20), clamped and signed.
	logic [16:0]        c_sum;
	logic [16:0]        c_mag;
	logic signed [16:0] c;
	always_comb begin
		c_sum = {1'b0, abs_a_q} + {1'b0, qp_q};
		c_mag = (c_sum > 17'd32440) ? 17'd32440 : c_sum;
		c     = neg_q ? -c_mag : c_mag;
	end

	// Stage output, history update and reciprocal split of |a|.
	logic signed [23:0] y_new;
	logic signed [23:0] h_new;
	logic [10:0]        qa_w;
	logic [5:0]         rsum;
	logic [CW-1:0]      stg_nx;
	logic [CW-1:0]      wb;
	always_comb begin
		y_new  = sat24(48'(hist_q[stg_q[IW-1:0]]) - ((48'(prod_q) + 48'sd16384) >>> 15));
		h_new  = sat24(48'(x_q) - ((48'(prod_q) + 48'sd16384) >>> 15));
		qa_w   = prod_q[30:20];
		rsum   = {1'b0, rem_q} + {1'b0, ra_q};
		stg_nx = stg_q + CW'(1);
		wb     = stg_q - CW'(1);
	end

	// Final mix and output magnitude.
	logic signed [47:0] mix_sum;
	logic signed [15:0] res;
	logic signed [16:0] r17;
	logic [16:0]        mag;
	logic [15:0]        pk_new;
	always_comb begin
		mix_sum = 48'(acc_q) + 48'(prod_q);
		res     = sat16((mix_sum + 48'sd32768) >>> 16);
		r17     = 17'(res);
		mag     = (r17 < 17'sd0) ? 17'(-r17) : 17'(r17);
		pk_new  = (mag[15:0] > peak_q) ? mag[15:0] : peak_q;
	end

	// Multiplier operand selection by sequencer step. The wet product is held
	// while the final step waits for the output register.
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_LFO: begin
				mreq.a = {8'd0, dep_q};
				mreq.b = lfo;
			end
			ST_IDX: begin
				mreq.a = 25'(wet_q);
				mreq.b = {2'd0, fb_q};
			end
			ST_DIV: begin
				mreq.a = {9'd0, abs_a_q};
				mreq.b = 18'sd52429;
			end
			ST_A: begin
				mreq.a = 25'(y_q);
				mreq.b = 18'(c);
			end
			ST_B: begin
				mreq.a = 25'(y_new);
				mreq.b = 18'(c);
			end
			ST_W: begin
				mreq.a = 25'(dry_q);
				mreq.b = {1'b0, 17'(18'd65536 - {1'b0, mix_q})};
			end
			ST_M1, ST_M2: begin
				mreq.a = 25'(y_q);
				mreq.b = {1'b0, mix_q};
			end
			default: mreq = '0;
		endcase
	end

	// Stage count write value, clamped to the available stages.
	logic [4:0] n5;
	always_comb begin
		n5 = {1'b0, cfg_data[3:0]};
		if (n5 == 5'd0) n5 = 5'd1;
		else if (n5 > MAX5) n5 = MAX5;
	end

	// The output register loads when the final step finds it free or draining.
	logic out_load;
	assign out_load = (state_q == ST_M2) && (!out_valid_q || out_ready);

	// Sequencer, configuration, state and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_step_q <= 21'd44739;
			dep_q        <= 17'd32768;
			cnt_q        <= CW'((MAX_STAGES < 4) ? MAX_STAGES : 4);
			fb_q         <= '0;
			mix_q        <= 17'd32768;
			shape_q      <= SHAPE_SINE;
			phase_q      <= '0;
			wet_q        <= '0;
			peak_q       <= '0;
			for (int i = 0; i < MAX_STAGES; i++) hist_q[i] <= '0;
			rem_q        <= '0;
			stg_q        <= '0;
			out_valid_q  <= 1'b0;
			frame_peak_q <= '0;
			last_q       <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			// Configuration writes must arrive only while idle; this is not enforced.
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PHASE_STEP: phase_step_q <= cfg_data;
					REG_DEPTH: dep_q <= (cfg_data[16:0] > 17'd65536) ? 17'd65536
						: cfg_data[16:0];
					REG_STAGES: begin
						cnt_q <= CW'(n5);
						for (int i = 0; i < MAX_STAGES; i++) begin
							if (5'(i) >= n5) hist_q[i] <= '0;
						end
					end
					REG_FEEDBACK: fb_q <= (cfg_data[15:0] > 16'd62259) ? 16'd62259
						: cfg_data[15:0];
					REG_MIX: mix_q <= (cfg_data[16:0] > 17'd65536) ? 17'd65536
						: cfg_data[16:0];
					REG_SHAPE: shape_q <= cfg_data[1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						dry_q   <= sample;
						fend_q  <= frame_end;
						phase_q <= phase_q + {11'd0, phase_step_q};
						state_q <= ST_LFO;
					end
				end
				ST_LFO: state_q <= ST_IDX;
				ST_IDX: begin
					idx_q   <= idx_sum[23:16];
					state_q <= ST_COEF;
				end
				ST_COEF: begin
					abs_a_q <= (a_tbl < 17'sd0) ? 16'(-a_tbl) : 16'(a_tbl);
					neg_q   <= (a_tbl < 17'sd0);
					x_q     <= x_in;
					y_q     <= x_in;
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DIV2;
				ST_DIV2: begin
					qa_q    <= qa_w;
					ra_q    <= 5'(abs_a_q - ({qa_w, 4'd0} + {2'd0, qa_w, 2'd0}));
					qp_q    <= '0;
					rem_q   <= '0;
					stg_q   <= '0;
					state_q <= ST_A;
				end
				ST_A: begin
					// Write back the previous stage's history.
					if (stg_q != '0) hist_q[wb[IW-1:0]] <= h_new;
					x_q     <= y_q;
					state_q <= ST_B;
				end
				ST_B: begin
					y_q   <= y_new;
					stg_q <= stg_nx;
					if (rsum >= 6'd20) begin
						rem_q <= 5'(rsum - 6'd20);
						qp_q  <= qp_q + {5'd0, qa_q} + 16'd1;
					end else begin
						rem_q <= rsum[4:0];
						qp_q  <= qp_q + {5'd0, qa_q};
					end
					state_q <= (stg_nx == cnt_q) ? ST_W : ST_A;
				end
				ST_W: begin
					hist_q[wb[IW-1:0]] <= h_new;
					wet_q   <= y_q;
					state_q <= ST_M1;
				end
				ST_M1: begin
					acc_q   <= prod_q;
					state_q <= ST_M2;
				end
				ST_M2: begin
					if (out_load) begin
						out_sample_q <= res;
						last_q       <= fend_q;
						if (fend_q) begin
							frame_peak_q <= pk_new;
							peak_q       <= '0;
						end else begin
							frame_peak_q <= '0;
							peak_q       <= pk_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on sequencer and output behavior.
	`LSAP_ASSERT_IMP(a_peak_zero, clk, arst_n, out_valid && !last, frame_peak == 16'd0)
	`LSAP_ASSERT_IMP(a_stage_range, clk, arst_n, state_q == ST_A || state_q == ST_B, stg_q < cnt_q)
	`LSAP_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`LSAP_ASSERT_IMP(a_rem_range, clk, arst_n, state_q == ST_A || state_q == ST_B, rem_q < 5'd20)

endmodule

FILE: verif/lfo_swept_allpass_phaser_tb.sv
// Self-checking testbench of the LFO-swept all-pass phaser with its own bit-exact predictor.
module lfo_swept_allpass_phaser_tb;
	import lsap_pkg::*;

	// One result transaction of the block.
	typedef struct {
		logic signed [15:0] smp;
		logic [15:0]        pk;
		logic               lst;
	} phaser_out_t;

	// One row of the directed stimulus table.
	typedef struct {
		logic signed [15:0] smp;
		logic               fe;
		bit                 typed;
		logic signed [15:0] want_smp;
		logic [15:0]        want_pk;
	} dir_row_t;

	localparam int N_STAGES   = 12;
	localparam int N_TYPED    = 7;
	localparam int LATENCY    = 2 * N_STAGES + 9;
	localparam int CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] sample;
	logic               frame_end;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] out_sample;
	logic [15:0]        frame_peak;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [20:0]        cfg_data;

	// Predictor copy of the configuration and the state.
	logic [31:0]        r_step;
	logic [31:0]        r_depth;
	logic [31:0]        r_stages;
	logic [31:0]        r_feedback;
	logic [31:0]        r_mix;
	logic [1:0]         r_shape;
	logic [31:0]        sweep_phase;
	longint             wet_state;
	longint             stage_mem [N_STAGES];
	longint             peak_hold;

	phaser_out_t        pending_outputs [$];
	int                 fails;
	int                 cycles;
	int                 tx_idle_pct;
	int                 rx_idle_pct;
	int                 rx_hold;
	dir_row_t           dir_tbl [$];

	lfo_swept_allpass_phaser u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.frame_peak (frame_peak),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock and the cycle budget of the whole run.
	initial begin
		clk = 1'b0;
		cycles = 0;
		forever begin
			#1 clk = ~clk;
			if (clk) begin
				cycles++;
				if (cycles > CYCLE_LIMIT) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Rounded arithmetic shift: floor((v + 2^(k-1)) / 2^k).
	function automatic longint round_shift(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	// Quarter-wave folded odd polynomial sine; turn in Q32, result in Q30.
	function automatic longint quarter_sine(input logic [31:0] turn);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		x  = turn[30] ? ((64'd1 << 30) - 64'(turn[29:0])) : 64'(turn[29:0]);
		x2 = (x * x) >> 30;
		t  = 64'd85569306 - ((x2 * 64'd5026995) >> 30);
		t  = 64'd693598668 - ((x2 * t) >> 30);
		t  = 64'd1686629713 - ((x2 * t) >> 30);
		v  = (x * t) >> 30;
		if (v > (64'd1 << 30)) v = 64'd1 << 30;
		return turn[31] ? -longint'(v) : longint'(v);
	endfunction

	// Current LFO output in Q1.15.
	function automatic longint sweep_value();
		longint      p16;
		longint      s;
		longint      m;
		p16 = longint'(sweep_phase[31:16]);
		if (r_shape == SHAPE_TRI)
			return (p16 < 32768) ? 2 * p16 - 32768 : 98304 - 2 * p16;
		if (r_shape == SHAPE_SQUARE)
			return (p16 < 32768) ? 32768 : -32768;
		s = quarter_sine({sweep_phase[31:24], 24'd0});
		m = (s < 0) ? -s : s;
		m = (m + 16384) >>> 15;
		if (m > 32767) m = 32767;
		return (s < 0) ? -m : m;
	endfunction

	// All-pass coefficient for one entry of the 200 Hz to 8000 Hz sweep.
	function automatic longint allpass_coeff(input longint idx);
		logic [63:0] num;
		logic [31:0] turn;
		longint      sn;
		longint      cs;
		longint      den;
		num  = (64'd51000 + 64'd7800 * 64'(idx)) << 31;
		turn = 32'(num / 64'd12240000);
		sn   = quarter_sine(turn);
		cs   = quarter_sine(turn + 32'h4000_0000);
		den  = cs + sn;
		if (den <= 0) return 0;
		return ((cs - sn) * 32768) / den;
	endfunction

	function automatic int live_stages();
		if (r_stages < 1) return 1;
		if (r_stages > N_STAGES) return N_STAGES;
		return int'(r_stages);
	endfunction

	// Register write as the block sees it.
	function automatic void apply_reg(input logic [2:0] idx, input logic [20:0] data);
		int n;
		case (idx)
			REG_PHASE_STEP: r_step = 32'(data);
			REG_DEPTH:      r_depth = 32'(data[16:0]);
			REG_STAGES: begin
				r_stages = 32'(data[3:0]);
				n = live_stages();
				for (int s = n; s < N_STAGES; s++) stage_mem[s] = 0;
			end
			REG_FEEDBACK:   r_feedback = 32'(data[15:0]);
			REG_MIX:        r_mix = 32'(data[16:0]);
			REG_SHAPE:      r_shape = data[1:0];
			default: ;
		endcase
	endfunction

	// Runs one sample through the phaser and returns the expected result.
	function automatic phaser_out_t phaser_step(input logic signed [15:0] dry_in,
			input logic fe);
		phaser_out_t r;
		longint      dry;
		longint      dep;
		longint      mx;
		longint      fb;
		longint      u;
		longint      idx;
		longint      a;
		longint      c;
		longint      x;
		longint      y;
		longint      res;
		longint      mag;
		int          n;
		dry = longint'(dry_in);
		dep = (r_depth > 65536) ? 65536 : longint'(r_depth);
		mx  = (r_mix > 65536) ? 65536 : longint'(r_mix);
		fb  = (r_feedback > 62259) ? 62259 : longint'(r_feedback);
		n   = live_stages();
		sweep_phase = sweep_phase + r_step;
		u   = clamp(32768 + ((dep * sweep_value()) >>> 16), 0, 65536);
		idx = (u * 255 + 32768) >>> 16;
		a   = allpass_coeff(idx);
		x   = clamp(dry + round_shift(fb * wet_state, 16), -8388608, 8388607);
		for (int s = 0; s < n; s++) begin
			c = clamp((a * (20 + s)) / 20, -32440, 32440);
			y = clamp(stage_mem[s] - round_shift(c * x, 15), -8388608, 8388607);
			stage_mem[s] = clamp(x - round_shift(c * y, 15), -8388608, 8388607);
			x = y;
		end
		wet_state = x;
		res = clamp(round_shift(dry * (65536 - mx) + x * mx, 16), -32768, 32767);
		mag = (res < 0) ? -res : res;
		if (mag > peak_hold) peak_hold = mag;
		r.smp = 16'(res);
		r.lst = fe;
		r.pk  = '0;
		if (fe) begin
			r.pk = 16'(peak_hold);
			peak_hold = 0;
		end
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		fails++;
	endtask

	// Result checker: each output transaction against the oldest expectation.
	always @(posedge clk) begin
		phaser_out_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				report("unexpected output", out_sample, 0);
			end else begin
				w = pending_outputs.pop_front();
				if (out_sample !== w.smp) report("out_sample", out_sample, w.smp);
				if (frame_peak !== w.pk) report("frame_peak", frame_peak, w.pk);
				if (last !== w.lst) report("last", last, w.lst);
			end
		end
	end

	// Output side back-pressure, with an optional long hold-off.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offers one sample transaction and logs its expected result on acceptance.
	task automatic send_sample(input logic signed [15:0] smp, input logic fe,
			input bit typed, input logic signed [15:0] want_smp, input logic [15:0] want_pk);
		phaser_out_t p;
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid = 1'b1;
		sample = smp;
		frame_end = fe;
		do @(posedge clk); while (!in_ready);
		p = phaser_step(smp, fe);
		if (typed) begin
			p.smp = want_smp;
			p.pk = want_pk;
		end
		pending_outputs.push_back(p);
	endtask

	// Waits for every expected result, then lets the pipeline settle.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_outputs.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [20:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(input logic [20:0] stp, input logic [20:0] dep,
			input logic [20:0] stg, input logic [20:0] fb, input logic [20:0] mx,
			input logic [20:0] shp);
		write_reg(REG_PHASE_STEP, stp);
		write_reg(REG_DEPTH, dep);
		write_reg(REG_STAGES, stg);
		write_reg(REG_FEEDBACK, fb);
		write_reg(REG_MIX, mx);
		write_reg(REG_SHAPE, shp);
	endtask

	// Main sequence: reset, directed table, then configured random phases.
	initial begin
		logic signed [15:0] smp;
		int                 sel;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		frame_end = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PHASE_STEP;
		cfg_data = '0;
		fails = 0;
		rx_hold = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 53;
		r_step = 44739;
		r_depth = 32768;
		r_stages = 4;
		r_feedback = 0;
		r_mix = 32768;
		r_shape = SHAPE_SINE;
		sweep_phase = '0;
		wet_state = 0;
		peak_hold = 0;
		for (int s = 0; s < N_STAGES; s++) stage_mem[s] = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// With a fully dry mix the output equals the input and the peak is easy to read.
		dir_tbl = '{
			'{16'sd32767, 1'b0, 1'b1, 16'sd32767, 16'd0},
			'{-16'sd32768, 1'b1, 1'b1, -16'sd32768, 16'd32768},
			'{16'sd0, 1'b1, 1'b1, 16'sd0, 16'd0},
			'{16'sd1, 1'b0, 1'b1, 16'sd1, 16'd0},
			'{-16'sd1, 1'b1, 1'b1, -16'sd1, 16'd1},
			'{-16'sd32768, 1'b0, 1'b1, -16'sd32768, 16'd0},
			'{16'sd32767, 1'b1, 1'b1, 16'sd32767, 16'd32768},
			'{16'sd32767, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{16'sd32767, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{16'sd32767, 1'b1, 1'b0, 16'sd0, 16'd0},
			'{-16'sd32768, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{-16'sd32768, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{-16'sd32768, 1'b1, 1'b0, 16'sd0, 16'd0},
			'{16'sd0, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{16'sd12345, 1'b0, 1'b0, 16'sd0, 16'd0},
			'{-16'sd21846, 1'b1, 1'b0, 16'sd0, 16'd0}
		};
		write_reg(REG_MIX, 21'd0);
		foreach (dir_tbl[i]) begin
			// After the typed rows, switch to a fully wet mix with maximum feedback.
			if (i == N_TYPED) begin
				drain();
				write_reg(REG_MIX, 21'd65536);
				write_reg(REG_FEEDBACK, 21'd62259);
				write_reg(REG_STAGES, 21'd12);
			end
			send_sample(dir_tbl[i].smp, dir_tbl[i].fe, dir_tbl[i].typed,
				dir_tbl[i].want_smp, dir_tbl[i].want_pk);
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < 10; p++) begin
			drain();
			if (p < 4) begin
				tx_idle_pct = 10;
				rx_idle_pct = 53;
			end else if (p < 7) begin
				tx_idle_pct = 53;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (p)
				0: write_all(21'd894, 21'd0, 21'd1, 21'd0, 21'd65536, 21'(SHAPE_SINE));
				1: write_all(21'd1789570, 21'd65536, 21'd12, 21'd62259, 21'd0,
					21'(SHAPE_TRI));
				2: write_all(21'h1F_FFFF, 21'h1_FFFF, 21'd15, 21'hFFFF, 21'h1_FFFF,
					21'(SHAPE_SQUARE));
				3: write_all(21'($urandom_range(894, 1789570)), 21'($urandom_range(65536)),
					21'd0, 21'($urandom_range(62259)), 21'($urandom_range(65536)), 21'd3);
				default: write_all(21'($urandom_range(894, 1789570)),
					21'($urandom_range(65536)), 21'($urandom_range(1, 12)),
					21'($urandom_range(62259)), 21'($urandom_range(65536)),
					21'($urandom_range(2)));
			endcase
			for (int k = 0; k < 50; k++) begin
				// The receiver stalls long enough for the block to back up its input.
				if (p == 3 && k == 5) rx_hold = 300;
				// The sender stops until every result is back.
				if (p == 5 && k == 25) begin
					@(negedge clk);
					in_valid = 1'b0;
					wait (pending_outputs.size() == 0);
				end
				sel = $urandom_range(9);
				if (sel == 0) smp = 16'sd32767;
				else if (sel == 1) smp = -16'sd32768;
				else smp = 16'($urandom);
				send_sample(smp, ($urandom_range(7) == 0), 1'b0, '0, '0);
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_outputs.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
